/* hdl/lrp_pkg.sv */
`timescale 1ns / 1ps

package lrp_pkg;

	localparam int LED_COUNT = 6;
	localparam int HEAD_W    = $clog2(LED_COUNT);

	localparam int MODE_W   = 4;
	localparam int TIME_W   = 32;
	localparam int COLOUR_W = 24;
	localparam int CHAN_W   = 8;

	localparam logic [MODE_W-1:0] MODE_BOOT     = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ONBOARD  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_LOADING  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_PLAYING  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_PAUSED   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_LISTEN   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SPEAK    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd8;
	localparam logic [MODE_W-1:0] MODE_NO_WIFI  = 4'd9;

	localparam int DIV_W    = 12;
	localparam int STEP_W   = 8;
	localparam int RECIP_W  = 24;
	localparam int W_W      = 11;
	localparam int PEAK_W   = 8;
	localparam int PROD2_W  = W_W + PEAK_W;
	localparam int HRECIP_W = 21;
	localparam int HSHIFT   = 29;

	localparam int STEP_BOOT  = 80;
	localparam int STEP_PLAY  = 120;
	localparam int STEP_SPEAK = 70;
	localparam int BLINK_MS   = 250;

	localparam int PERIOD_ONBOARD = 1200;
	localparam int PERIOD_IDLE    = 4000;
	localparam int PERIOD_LISTEN  = 900;
	localparam int PERIOD_NO_WIFI = 2000;

	localparam int PEAK_ONBOARD = 180;
	localparam int PEAK_IDLE    = 40;
	localparam int PEAK_LISTEN  = 200;
	localparam int PEAK_NO_WIFI = 150;

	localparam int DIV_BOOT  = LED_COUNT * STEP_BOOT;
	localparam int DIV_PLAY  = LED_COUNT * STEP_PLAY;
	localparam int DIV_SPEAK = LED_COUNT * STEP_SPEAK;
	localparam int DIV_ERROR = 2 * BLINK_MS;

	localparam logic [RECIP_W-1:0] RCP_BOOT    = RECIP_W'((64'd1 << TIME_W) / 64'(DIV_BOOT));
	localparam logic [RECIP_W-1:0] RCP_PLAY    = RECIP_W'((64'd1 << TIME_W) / 64'(DIV_PLAY));
	localparam logic [RECIP_W-1:0] RCP_SPEAK   = RECIP_W'((64'd1 << TIME_W) / 64'(DIV_SPEAK));
	localparam logic [RECIP_W-1:0] RCP_ERROR   = RECIP_W'((64'd1 << TIME_W) / 64'(DIV_ERROR));
	localparam logic [RECIP_W-1:0] RCP_ONBOARD =
		RECIP_W'((64'd1 << TIME_W) / 64'(PERIOD_ONBOARD));
	localparam logic [RECIP_W-1:0] RCP_IDLE    = RECIP_W'((64'd1 << TIME_W) / 64'(PERIOD_IDLE));
	localparam logic [RECIP_W-1:0] RCP_LISTEN  = RECIP_W'((64'd1 << TIME_W) / 64'(PERIOD_LISTEN));
	localparam logic [RECIP_W-1:0] RCP_NO_WIFI =
		RECIP_W'((64'd1 << TIME_W) / 64'(PERIOD_NO_WIFI));

	localparam int HALF_ONBOARD = PERIOD_ONBOARD / 2;
	localparam int HALF_IDLE    = PERIOD_IDLE / 2;
	localparam int HALF_LISTEN  = PERIOD_LISTEN / 2;
	localparam int HALF_NO_WIFI = PERIOD_NO_WIFI / 2;

	localparam logic [HRECIP_W-1:0] HRCP_ONBOARD =
		HRECIP_W'(((64'd1 << HSHIFT) + 64'(HALF_ONBOARD) - 64'd1) / 64'(HALF_ONBOARD));
	localparam logic [HRECIP_W-1:0] HRCP_IDLE =
		HRECIP_W'(((64'd1 << HSHIFT) + 64'(HALF_IDLE) - 64'd1) / 64'(HALF_IDLE));
	localparam logic [HRECIP_W-1:0] HRCP_LISTEN =
		HRECIP_W'(((64'd1 << HSHIFT) + 64'(HALF_LISTEN) - 64'd1) / 64'(HALF_LISTEN));
	localparam logic [HRECIP_W-1:0] HRCP_NO_WIFI =
		HRECIP_W'(((64'd1 << HSHIFT) + 64'(HALF_NO_WIFI) - 64'd1) / 64'(HALF_NO_WIFI));

	// ring period for chases, two half periods for the blink, full period for breaths
	function automatic logic [DIV_W-1:0] divisor_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_PLAYING: return DIV_W'(DIV_PLAY);
			MODE_SPEAK:   return DIV_W'(DIV_SPEAK);
			MODE_ERROR:   return DIV_W'(DIV_ERROR);
			MODE_ONBOARD: return DIV_W'(PERIOD_ONBOARD);
			MODE_IDLE:    return DIV_W'(PERIOD_IDLE);
			MODE_LISTEN:  return DIV_W'(PERIOD_LISTEN);
			MODE_NO_WIFI: return DIV_W'(PERIOD_NO_WIFI);
			default:      return DIV_W'(DIV_BOOT);
		endcase
	endfunction

	function automatic logic [RECIP_W-1:0] recip_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_PLAYING: return RCP_PLAY;
			MODE_SPEAK:   return RCP_SPEAK;
			MODE_ERROR:   return RCP_ERROR;
			MODE_ONBOARD: return RCP_ONBOARD;
			MODE_IDLE:    return RCP_IDLE;
			MODE_LISTEN:  return RCP_LISTEN;
			MODE_NO_WIFI: return RCP_NO_WIFI;
			default:      return RCP_BOOT;
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] step_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_PLAYING: return STEP_W'(STEP_PLAY);
			MODE_SPEAK:   return STEP_W'(STEP_SPEAK);
			MODE_ERROR:   return STEP_W'(BLINK_MS);
			default:      return STEP_W'(STEP_BOOT);
		endcase
	endfunction

	function automatic logic [DIV_W-1:0] period_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_ONBOARD: return DIV_W'(PERIOD_ONBOARD);
			MODE_IDLE:    return DIV_W'(PERIOD_IDLE);
			MODE_LISTEN:  return DIV_W'(PERIOD_LISTEN);
			MODE_NO_WIFI: return DIV_W'(PERIOD_NO_WIFI);
			default:      return '0;
		endcase
	endfunction

	function automatic logic [PEAK_W-1:0] peak_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_ONBOARD: return PEAK_W'(PEAK_ONBOARD);
			MODE_IDLE:    return PEAK_W'(PEAK_IDLE);
			MODE_LISTEN:  return PEAK_W'(PEAK_LISTEN);
			MODE_NO_WIFI: return PEAK_W'(PEAK_NO_WIFI);
			default:      return '0;
		endcase
	endfunction

	function automatic logic [HRECIP_W-1:0] hrecip_of(input logic [MODE_W-1:0] m);
		case (m)
			MODE_ONBOARD: return HRCP_ONBOARD;
			MODE_IDLE:    return HRCP_IDLE;
			MODE_LISTEN:  return HRCP_LISTEN;
			MODE_NO_WIFI: return HRCP_NO_WIFI;
			default:      return '0;
		endcase
	endfunction

endpackage

/* hdl/lrp_if.sv */
`timescale 1ns / 1ps

interface lrp_req_if import lrp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [TIME_W-1:0]   time_ms;

	modport source (output valid, mode, time_ms, input ready);
	modport sink   (input valid, mode, time_ms, output ready);
endinterface

interface lrp_rsp_if import lrp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] led0_color;
	logic [COLOUR_W-1:0] led1_color;
	logic [COLOUR_W-1:0] led2_color;
	logic [COLOUR_W-1:0] led3_color;
	logic [COLOUR_W-1:0] led4_color;
	logic [COLOUR_W-1:0] led5_color;

	modport source (output valid, led0_color, led1_color, led2_color, led3_color,
		led4_color, led5_color, input ready);
	modport sink   (input valid, led0_color, led1_color, led2_color, led3_color,
		led4_color, led5_color, output ready);
endinterface

/* hdl/lrp_remainder.sv */
`timescale 1ns / 1ps

module lrp_remainder import lrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lrp_req_if.sink           req,
	output logic              rem_valid,
	input  logic              rem_ready,
	output logic [MODE_W-1:0] rem_mode,
	output logic [DIV_W-1:0]  rem
);

	localparam int P1_W = TIME_W + RECIP_W;
	localparam int QD_W = RECIP_W + DIV_W;

	logic              vld_s1, vld_s2, vld_s3;
	logic              en_s1, en_s2, en_s3;

	logic [MODE_W-1:0]  mode_s1, mode_s2, mode_s3;
	logic [TIME_W-1:0]  t_s1, t_s2;
	logic [RECIP_W-1:0] q_s1;
	logic [TIME_W-1:0]  qd_s2;
	logic [DIV_W-1:0]   rem_s3;

	logic [P1_W-1:0]    prod1;
	logic [QD_W-1:0]    qd;
	logic [TIME_W-1:0]  diff, dv, rfix;

	assign en_s3 = !vld_s3 || rem_ready;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign req.ready = en_s1;

	// estimate quotient, low by at most one
	assign prod1 = P1_W'(req.time_ms) * P1_W'(recip_of(req.mode));
	assign qd    = QD_W'(q_s1) * QD_W'(divisor_of(mode_s1));

	assign diff = t_s2 - qd_s2;
	assign dv   = TIME_W'(divisor_of(mode_s2));
	assign rfix = (diff >= dv) ? diff - dv : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= req.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= req.mode;
			t_s1    <= req.time_ms;
			q_s1    <= prod1[TIME_W +: RECIP_W];
		end
		if (en_s2) begin
			mode_s2 <= mode_s1;
			t_s2    <= t_s1;
			qd_s2   <= qd[TIME_W-1:0];
		end
		if (en_s3) begin
			mode_s3 <= mode_s2;
			rem_s3  <= rfix[DIV_W-1:0];
		end
	end

	assign rem_valid = vld_s3;
	assign rem_mode  = mode_s3;
	assign rem       = rem_s3;

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> rem_s3 < divisor_of(mode_s3))
		else $error("remainder not below divisor");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> vld_s1 && vld_s2 && vld_s3 && !rem_ready)
		else $error("input blocked with room in the pipeline");

endmodule

/* hdl/led_ring_pattern_generator.sv */
`timescale 1ns / 1ps

// channel | interface   | payload
// req     | lrp_req_if  | mode, time_ms
// rsp     | lrp_rsp_if  | led0_color .. led5_color
//
// one item per cycle unless rsp stalls; seven register stages from acceptance to result
// depth set by the reciprocal and divisor multiplies of the remainder and the breath scale
// reset clears the stage valid bits only
// each stage holds while the next is full, so empty stages close up under a stall

module led_ring_pattern_generator import lrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lrp_req_if.sink   req,
	lrp_rsp_if.source rsp
);

	localparam int P3_W        = PROD2_W + HRECIP_W;
	localparam int THIRD_MUL   = 171;
	localparam int THIRD_SHIFT = 9;
	localparam int THIRD_W     = 2 * CHAN_W;

	localparam logic [COLOUR_W-1:0] COL_WHITE      = 24'hFFFFFF;
	localparam logic [COLOUR_W-1:0] COL_GREY       = 24'h202020;
	localparam logic [COLOUR_W-1:0] COL_GREEN      = 24'h00FF00;
	localparam logic [COLOUR_W-1:0] COL_GREEN_DIM  = 24'h002000;
	localparam logic [COLOUR_W-1:0] COL_GREEN_HOLD = 24'h005000;
	localparam logic [COLOUR_W-1:0] COL_VIOLET     = 24'hC800FF;
	localparam logic [COLOUR_W-1:0] COL_VIOLET_DIM = 24'h280050;
	localparam logic [COLOUR_W-1:0] COL_RED        = 24'hFF0000;
	localparam logic [COLOUR_W-1:0] COL_OFF        = 24'h000000;

	logic              rem_valid, rem_ready;
	logic [MODE_W-1:0] rem_mode;
	logic [DIV_W-1:0]  rem;

	lrp_remainder u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rem_valid (rem_valid),
		.rem_ready (rem_ready),
		.rem_mode  (rem_mode),
		.rem       (rem)
	);

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s4, en_s5, en_s6, en_s7;

	logic [MODE_W-1:0]  mode_s4, mode_s5, mode_s6;
	logic [HEAD_W-1:0]  head_s4, head_s5, head_s6;
	logic [W_W-1:0]     w_s4;
	logic [PROD2_W-1:0] prod2_s5;
	logic [CHAN_W-1:0]  v_s6;
	logic [COLOUR_W-1:0] colour_s7 [LED_COUNT];

	logic [HEAD_W-1:0]   head;
	logic [DIV_W-1:0]    period, half;
	logic [W_W-1:0]      w;
	logic [PROD2_W-1:0]  prod2;
	logic [P3_W-1:0]     prod3;
	logic [THIRD_W-1:0]  third;
	logic [CHAN_W-1:0]   v_third;
	logic [COLOUR_W-1:0] colour [LED_COUNT];

	assign en_s7 = !vld_s7 || rsp.ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign rem_ready = en_s4;

	// head position within the ring, or blink phase
	always_comb begin
		head = '0;
		for (int k = 1; k < LED_COUNT; k++) begin
			if (rem >= DIV_W'(k) * DIV_W'(step_of(rem_mode))) head = head + HEAD_W'(1);
		end
	end

	// triangle distance from the nearest end of the period
	assign period = period_of(rem_mode);
	assign half   = period >> 1;
	assign w      = (rem < half) ? rem[W_W-1:0] : W_W'(period - rem);

	assign prod2 = PROD2_W'(w_s4) * PROD2_W'(peak_of(mode_s4));
	assign prod3 = P3_W'(prod2_s5) * P3_W'(hrecip_of(mode_s5));

	assign third   = THIRD_W'(v_s6) * THIRD_W'(THIRD_MUL);
	assign v_third = CHAN_W'(third >> THIRD_SHIFT);

	always_comb begin
		logic [HEAD_W-1:0] lag;
		logic [CHAN_W-1:0] tail;
		for (int i = 0; i < LED_COUNT; i++) begin
			lag = (HEAD_W'(i) >= head_s6) ? HEAD_W'(i) - head_s6
				: HEAD_W'(i) + HEAD_W'(LED_COUNT) - head_s6;
			tail = 8'hFF >> lag;
			case (mode_s6)
				MODE_BOOT:    colour[i] = (HEAD_W'(i) == head_s6) ? COL_WHITE : COL_GREY;
				MODE_ONBOARD: colour[i] = {16'h0000, v_s6};
				MODE_IDLE:    colour[i] = {v_s6, 1'b0, v_s6[CHAN_W-1:1], 8'h00};
				MODE_LOADING: colour[i] = {tail, tail, tail};
				MODE_PLAYING: colour[i] = (HEAD_W'(i) == head_s6) ? COL_GREEN : COL_GREEN_DIM;
				MODE_PAUSED:  colour[i] = COL_GREEN_HOLD;
				MODE_LISTEN:  colour[i] = {1'b0, v_s6[CHAN_W-1:1], 8'h00, v_s6};
				MODE_SPEAK:   colour[i] = (HEAD_W'(i) == head_s6) ? COL_VIOLET : COL_VIOLET_DIM;
				MODE_ERROR:   colour[i] = head_s6[0] ? COL_RED : COL_OFF;
				MODE_NO_WIFI: colour[i] = {v_s6, v_third, 8'h00};
				default:      colour[i] = COL_OFF;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s4) vld_s4 <= rem_valid;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			mode_s4 <= rem_mode;
			head_s4 <= head;
			w_s4    <= w;
		end
		if (en_s5) begin
			mode_s5  <= mode_s4;
			head_s5  <= head_s4;
			prod2_s5 <= prod2;
		end
		if (en_s6) begin
			mode_s6 <= mode_s5;
			head_s6 <= head_s5;
			v_s6    <= prod3[HSHIFT +: CHAN_W];
		end
		if (en_s7) begin
			for (int i = 0; i < LED_COUNT; i++) colour_s7[i] <= colour[i];
		end
	end

	assign rsp.valid      = vld_s7;
	assign rsp.led0_color = colour_s7[0];
	assign rsp.led1_color = colour_s7[1];
	assign rsp.led2_color = colour_s7[2];
	assign rsp.led3_color = colour_s7[3];
	assign rsp.led4_color = colour_s7[4];
	assign rsp.led5_color = colour_s7[5];

	a_head_on_ring: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> head_s4 < HEAD_W'(LED_COUNT))
		else $error("chase head off the ring");

	a_breath_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && (mode_s5 == MODE_ONBOARD || mode_s5 == MODE_IDLE ||
		mode_s5 == MODE_LISTEN || mode_s5 == MODE_NO_WIFI)
		|-> prod2_s5 <= PROD2_W'(period_of(mode_s5) >> 1) * PROD2_W'(peak_of(mode_s5)))
		else $error("breath product above half period times peak");

	a_blocked_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready)
		else $error("input blocked without an output stall");

endmodule

/* tb/led_ring_pattern_generator_tb.sv */
`timescale 1ns / 1ps

module led_ring_pattern_generator_tb import lrp_pkg::*; ();

	typedef logic [LED_COUNT-1:0][COLOUR_W-1:0] ring_frame_t;

	class ring_frame_board;
		ring_frame_t pending_frames[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		function automatic logic [COLOUR_W-1:0] rgb(input logic [31:0] r, g, b);
			return {r[7:0], g[7:0], b[7:0]};
		endfunction

		function automatic logic [31:0] breath_level(input logic [31:0] t, period, peak);
			logic [31:0] phase;
			logic [31:0] half;
			logic [31:0] w;
			phase = t % period;
			half  = period / 2;
			w     = (phase < half) ? phase : period - phase;
			return (w * peak) / half;
		endfunction

		function automatic ring_frame_t ring_colours(input logic [MODE_W-1:0] m,
			input logic [TIME_W-1:0] t);
			ring_frame_t f;
			logic [31:0] v;
			logic [31:0] head;
			logic [31:0] d;
			f = '0;
			case (m)
				MODE_BOOT: begin
					head = (t / STEP_BOOT) % LED_COUNT;
					f = {LED_COUNT{rgb(32, 32, 32)}};
					f[head] = rgb(255, 255, 255);
				end
				MODE_ONBOARD: begin
					v = breath_level(t, PERIOD_ONBOARD, PEAK_ONBOARD);
					f = {LED_COUNT{rgb(0, 0, v)}};
				end
				MODE_IDLE: begin
					v = breath_level(t, PERIOD_IDLE, PEAK_IDLE);
					f = {LED_COUNT{rgb(v, v / 2, 0)}};
				end
				MODE_LOADING: begin
					head = (t / STEP_BOOT) % LED_COUNT;
					for (int i = 0; i < LED_COUNT; i++) begin
						d = (i + LED_COUNT - head) % LED_COUNT;
						v = 255 >> d;
						f[i] = rgb(v, v, v);
					end
				end
				MODE_PLAYING: begin
					head = (t / STEP_PLAY) % LED_COUNT;
					f = {LED_COUNT{rgb(0, 32, 0)}};
					f[head] = rgb(0, 255, 0);
				end
				MODE_PAUSED: f = {LED_COUNT{rgb(0, 80, 0)}};
				MODE_LISTEN: begin
					v = breath_level(t, PERIOD_LISTEN, PEAK_LISTEN);
					f = {LED_COUNT{rgb(v / 2, 0, v)}};
				end
				MODE_SPEAK: begin
					head = (t / STEP_SPEAK) % LED_COUNT;
					f = {LED_COUNT{rgb(40, 0, 80)}};
					f[head] = rgb(200, 0, 255);
				end
				MODE_ERROR: begin
					v = t / BLINK_MS;
					f = v[0] ? {LED_COUNT{rgb(255, 0, 0)}} : '0;
				end
				MODE_NO_WIFI: begin
					v = breath_level(t, PERIOD_NO_WIFI, PEAK_NO_WIFI);
					f = {LED_COUNT{rgb(v, v / 3, 0)}};
				end
				default: f = '0;
			endcase
			return f;
		endfunction

		function void note_request(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
			pending_frames.push_back(ring_colours(m, t));
		endfunction

		function void check_frame(input ring_frame_t got);
			ring_frame_t want;
			if (pending_frames.size() == 0) begin
				$error("unexpected result item: %h", got);
				mismatches++;
				return;
			end
			want = pending_frames.pop_front();
			for (int i = 0; i < LED_COUNT; i++) begin
				if (got[i] !== want[i]) begin
					$error("led%0d_color: expected %06h, actual %06h", i, want[i], got[i]);
					mismatches++;
				end
			end
		endfunction

		function int pending_count();
			return pending_frames.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lrp_req_if req_ch ();
	lrp_rsp_if rsp_ch ();

	led_ring_pattern_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	ring_frame_board board = new();
	bit              calm;
	bit              idle_on;
	bit              hold_rsp;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_frame({rsp_ch.led5_color, rsp_ch.led4_color, rsp_ch.led3_color,
					rsp_ch.led2_color, rsp_ch.led1_color, rsp_ch.led0_color});
			if (req_ch.valid && req_ch.ready)
				board.note_request(req_ch.mode, req_ch.time_ms);
		end
	end

	function automatic logic [31:0] ring_span(input logic [MODE_W-1:0] m);
		case (m)
			MODE_PLAYING: return DIV_PLAY;
			MODE_SPEAK:   return DIV_SPEAK;
			MODE_ERROR:   return DIV_ERROR;
			MODE_ONBOARD: return PERIOD_ONBOARD;
			MODE_IDLE:    return PERIOD_IDLE;
			MODE_LISTEN:  return PERIOD_LISTEN;
			MODE_NO_WIFI: return PERIOD_NO_WIFI;
			default:      return DIV_BOOT;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_time(input logic [MODE_W-1:0] m);
		logic [31:0] span;
		logic [31:0] base;
		span = ring_span(m);
		// 252000 is a common multiple of every span, so offsets land on pattern edges
		base = $urandom_range(0, 17000) * 252000;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 20000);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
			3: return base + span / 2 - 1 + $urandom_range(0, 2);
			default: return base + span - 1 + $urandom_range(0, 1);
		endcase
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
		if (!calm && idle_on && $urandom_range(0, 2) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= m;
		req_ch.time_ms <= t;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (board.pending_count() != 0);
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("led_ring_pattern_generator_tb: FAIL");
		$finish;
	end

	initial begin
		logic [MODE_W-1:0] m;
		logic [TIME_W-1:0] t;
		logic [31:0]       stride;
		int                run_len;
		int                sent;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.mode    <= '0;
		req_ch.time_ms <= '0;
		calm     = 1'b0;
		idle_on  = 1'b1;
		hold_rsp = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every mode at time zero, the unused codes included
		for (int i = 0; i < 16; i++)
			send_item(MODE_W'(i), '0);
		send_item(MODE_BOOT, 32'hFFFF_FFFF);
		send_item(MODE_ONBOARD, HALF_ONBOARD - 1);
		send_item(MODE_ONBOARD, HALF_ONBOARD);
		send_item(MODE_ONBOARD, PERIOD_ONBOARD - 1);
		send_item(MODE_LOADING, DIV_BOOT - 1);
		send_item(MODE_ERROR, BLINK_MS - 1);
		send_item(MODE_ERROR, BLINK_MS);
		send_item(MODE_NO_WIFI, 32'hFFFF_FFFF);
		send_item(4'hF, 32'hFFFF_FFFF);

		sent = 0;
		while (sent < 1600) begin
			idle_on = ($urandom_range(0, 3) != 0);
			run_len = $urandom_range(1, 20);
			m = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(10, 15))
				: MODE_W'($urandom_range(0, 9));
			t = pick_time(m);
			stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 60);
			for (int k = 0; k < run_len; k++) begin
				send_item(m, t);
				t += stride;
				sent++;
				if (sent == 400)
					hold_rsp = 1'b1;
				if (sent == 800)
					drain_results();
				calm = (sent > 1400);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending_count() == 0) begin
			$display("led_ring_pattern_generator_tb: PASS");
		end else begin
			$display("led_ring_pattern_generator_tb: FAIL");
		end
		$finish;
	end

endmodule
